FILE: rtl/uedr_pkg.sv
// package: types, constants, descriptor rom and helpers for the ep0 descriptor responder
`timescale 1ns / 1ps
package uedr_pkg;

   localparam int RomTotal = 148;
   localparam int CmdDepth = 2;

   localparam logic [7:0] ReqSetAddress    = 8'd5;
   localparam logic [7:0] ReqGetDescriptor = 8'd6;
   localparam logic [7:0] DescDevice       = 8'd1;
   localparam logic [7:0] DescConfig       = 8'd2;
   localparam logic [7:0] DescString       = 8'd3;
   localparam logic [1:0] TypeStandard     = 2'd0;
   localparam logic [7:0] LastStringIndex  = 8'd3;
   localparam logic [6:0] MaxPacketReset   = 7'd16;
   localparam logic [6:0] MinPacket        = 7'd8;
   localparam logic [6:0] MaxPacket        = 7'd64;
   localparam logic [8:0] PacketSizeAddr   = 9'd7;

   localparam logic [7:0] DeviceBase = 8'd0;
   localparam logic [5:0] DeviceLen  = 6'd18;
   localparam logic [7:0] ConfigBase = 8'd18;
   localparam logic [5:0] ConfigLen  = 6'd34;

   localparam logic [7:0] DescRom [RomTotal] = '{
      // device
      8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h10, 8'h88, 8'h88,
      8'h01, 8'h00, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01,
      // configuration set
      8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
      8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h02, 8'h00,
      8'h09, 8'h21, 8'h10, 8'h01, 8'h21, 8'h01, 8'h22, 8'h01, 8'h00,
      8'h07, 8'h05, 8'h81, 8'h03, 8'h10, 8'h00, 8'h0a,
      // string 0
      8'h04, 8'h03, 8'h09, 8'h04,
      // string 1
      8'h2e, 8'h03, 8'h68, 8'h00, 8'h74, 8'h00, 8'h74, 8'h00, 8'h70, 8'h00, 8'h3a, 8'h00,
      8'h2f, 8'h00, 8'h2f, 8'h00, 8'h77, 8'h00, 8'h77, 8'h00, 8'h77, 8'h00, 8'h2e, 8'h00,
      8'h6c, 8'h00, 8'h69, 8'h00, 8'h73, 8'h00, 8'h6f, 8'h00, 8'h6e, 8'h00, 8'h67, 8'h00,
      8'h7a, 8'h00, 8'h65, 8'h00, 8'h2e, 8'h00, 8'h63, 8'h00, 8'h6e, 8'h00,
      // string 2
      8'h18, 8'h03, 8'h75, 8'h00, 8'h73, 8'h00, 8'h62, 8'h00, 8'h20, 8'h9f, 8'h07, 8'h68,
      8'h0c, 8'hff, 8'h62, 8'h00, 8'h79, 8'h00, 8'h4e, 8'h67, 8'h7e, 8'h67, 8'hfd, 8'h6c,
      // string 3
      8'h16, 8'h03, 8'h32, 8'h00, 8'h30, 8'h00, 8'h31, 8'h00, 8'h38, 8'h00, 8'h2d, 8'h00,
      8'h30, 8'h00, 8'h35, 8'h00, 8'h2d, 8'h00, 8'h32, 8'h00, 8'h30, 8'h00
   };

   typedef enum logic [1:0] {
      CMD_SEND,
      CMD_LOAD,
      CMD_ZLP,
      CMD_ADDR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] base;
      logic [7:0] len;
      logic       zlp;
      logic [7:0] addr;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_START,
      BK_SEND
   } back_state_type;

   function automatic logic [6:0] eff_packet(input logic [6:0] m);
      if (m < MinPacket) return MinPacket;
      if (m > MaxPacket) return MaxPacket;
      return m;
   endfunction

   function automatic logic [7:0] string_base(input logic [1:0] idx);
      case (idx)
         2'd0:    return 8'd52;
         2'd1:    return 8'd56;
         2'd2:    return 8'd102;
         default: return 8'd126;
      endcase
   endfunction

   function automatic logic [5:0] string_len(input logic [1:0] idx);
      case (idx)
         2'd0:    return 6'd4;
         2'd1:    return 6'd46;
         2'd2:    return 6'd24;
         default: return 6'd22;
      endcase
   endfunction

   function automatic logic [7:0] rom_byte(input logic [8:0] addr, input logic [6:0] mp);
      if (addr == PacketSizeAddr) return {1'b0, mp};
      if (addr >= 9'(RomTotal)) return 8'h00;
      return DescRom[addr[7:0]];
   endfunction

endpackage

FILE: rtl/uedr_ifs.sv
// channel interfaces: setup request, response byte and csr write
`timescale 1ns / 1ps

interface uedr_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  request_type;
   logic [7:0]  request_code;
   logic [15:0] setup_value;
   logic [15:0] setup_index;
   logic [15:0] setup_length;

   modport source (output valid, func, request_type, request_code, setup_value,
                   setup_index, setup_length, input ready);
   modport sink   (input valid, func, request_type, request_code, setup_value,
                   setup_index, setup_length, output ready);
endinterface

interface uedr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       packet_last;
   logic       address_valid;
   logic [7:0] new_address;

   modport source (output valid, data_byte, has_byte, packet_last, address_valid,
                   new_address, input ready);
   modport sink   (input valid, data_byte, has_byte, packet_last, address_valid,
                   new_address, output ready);
endinterface

interface uedr_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/uedr_front.sv
// front end: accepts request transfers and turns the supported ones into queued commands
`timescale 1ns / 1ps
module uedr_front
   import uedr_pkg::*;
(
   uedr_req_if.sink         req_ch,
   input  queue_status_type q_status,
   input  logic [6:0]       eff_mp,
   output logic             push,
   output cmd_type          push_cmd
);

   function automatic logic is_multiple(input logic [5:0] dlen, input logic [6:0] mp);
      logic [8:0] d;
      logic [8:0] m1;
      logic [8:0] m2;
      logic [8:0] m4;
      d  = {3'b0, dlen};
      m1 = {2'b0, mp};
      m2 = {1'b0, mp, 1'b0};
      m4 = {mp, 2'b0};
      return d == m1 || d == m2 || d == (m1 + m2) || d == m4 || d == (m4 + m1);
   endfunction

   logic       op_valid;
   logic [5:0] dlen;
   logic [7:0] base;
   logic       is_load;

   always_comb begin
      push_cmd = '0;
      op_valid = 1'b0;
      is_load  = 1'b0;
      dlen     = '0;
      base     = '0;
      if (req_ch.func) begin
         push_cmd.op = CMD_SEND;
         op_valid    = 1'b1;
      end else if (req_ch.request_type[6:5] != TypeStandard) begin
         op_valid = 1'b0;
      end else if (req_ch.request_type[7] && req_ch.request_code == ReqGetDescriptor) begin
         case (req_ch.setup_value[15:8])
            DescDevice: begin
               is_load = 1'b1;
               base    = DeviceBase;
               dlen    = DeviceLen;
            end
            DescConfig: begin
               is_load = 1'b1;
               base    = ConfigBase;
               dlen    = ConfigLen;
            end
            DescString: begin
               if (req_ch.setup_value[7:0] > LastStringIndex) begin
                  push_cmd.op = CMD_ZLP;
                  op_valid    = 1'b1;
               end else begin
                  is_load = 1'b1;
                  base    = string_base(req_ch.setup_value[1:0]);
                  dlen    = string_len(req_ch.setup_value[1:0]);
               end
            end
            default: op_valid = 1'b0;
         endcase
         if (is_load) begin
            op_valid      = 1'b1;
            push_cmd.op   = CMD_LOAD;
            push_cmd.base = base;
            if (req_ch.setup_length > {10'b0, dlen}) begin
               push_cmd.len = {2'b0, dlen};
               push_cmd.zlp = is_multiple(dlen, eff_mp);
            end else begin
               push_cmd.len = req_ch.setup_length[7:0];
            end
         end
      end else if (!req_ch.request_type[7] && req_ch.request_code == ReqSetAddress) begin
         push_cmd.op   = CMD_ADDR;
         push_cmd.addr = req_ch.setup_value[7:0];
         op_valid      = 1'b1;
      end
   end

   assign req_ch.ready = !q_status.full;
   assign push         = req_ch.valid && !q_status.full && op_valid;

endmodule

FILE: rtl/uedr_cmd_queue.sv
// two-entry command queue between front and back end
`timescale 1ns / 1ps
module uedr_cmd_queue
   import uedr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          pop_cmd,
   output queue_status_type q_status
);

   localparam int PtrBits = $clog2(CmdDepth);
   localparam int CntBits = $clog2(CmdDepth + 1);

   cmd_type              entries_ff [CmdDepth];
   logic [PtrBits-1:0]   wr_ptr_ff;
   logic [PtrBits-1:0]   rd_ptr_ff;
   logic [CntBits-1:0]   count_ff;
   logic [PtrBits-1:0]   wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_in;
   logic [CntBits-1:0]   count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(CmdDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(CmdDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd        = entries_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == CntBits'(CmdDepth);
   assign q_status.empty = count_ff == '0;

endmodule

FILE: rtl/uedr_back.sv
// back end: runs commands and emits packet bytes, zero-length and address results into the response register
`timescale 1ns / 1ps
module uedr_back
   import uedr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  cmd_type          pop_cmd,
   input  logic [6:0]       eff_mp,
   output logic             pop,
   uedr_rsp_if.source       rsp_ch
);

   back_state_type state_ff, state_in;
   logic [7:0] base_ff, base_in;
   logic [6:0] off_ff, off_in;
   logic [7:0] left_ff, left_in;
   logic       zlp_ff, zlp_in;
   logic [6:0] pkt_ff, pkt_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] data_byte_ff, data_byte_in;
   logic       has_byte_ff, has_byte_in;
   logic       last_ff, last_in;
   logic       av_ff, av_in;
   logic [7:0] addr_ff, addr_in;

   logic       out_free;
   logic       emit;
   logic [8:0] rom_addr;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign rom_addr = {1'b0, base_ff} + {2'b0, off_ff};

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      off_in       = off_ff;
      left_in      = left_ff;
      zlp_in       = zlp_ff;
      pkt_in       = pkt_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      data_byte_in = 8'h00;
      has_byte_in  = 1'b0;
      last_in      = 1'b0;
      av_in        = 1'b0;
      addr_in      = 8'h00;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty && out_free) begin
               pop = 1'b1;
               case (pop_cmd.op)
                  CMD_SEND: state_in = BK_START;
                  CMD_LOAD: begin
                     base_in  = pop_cmd.base;
                     off_in   = '0;
                     left_in  = pop_cmd.len;
                     zlp_in   = pop_cmd.zlp;
                     state_in = BK_START;
                  end
                  CMD_ZLP: begin
                     off_in   = '0;
                     left_in  = '0;
                     zlp_in   = 1'b1;
                     state_in = BK_START;
                  end
                  CMD_ADDR: begin
                     left_in = '0;
                     zlp_in  = 1'b0;
                     emit    = 1'b1;
                     last_in = 1'b1;
                     av_in   = 1'b1;
                     addr_in = pop_cmd.addr;
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_START: begin
            if (left_ff == '0) begin
               if (!zlp_ff) begin
                  state_in = BK_IDLE;
               end else if (out_free) begin
                  emit     = 1'b1;
                  last_in  = 1'b1;
                  zlp_in   = 1'b0;
                  state_in = BK_IDLE;
               end
            end else begin
               pkt_in   = (left_ff > {1'b0, eff_mp}) ? eff_mp : left_ff[6:0];
               state_in = BK_SEND;
            end
         end
         BK_SEND: begin
            if (out_free) begin
               emit         = 1'b1;
               has_byte_in  = 1'b1;
               data_byte_in = rom_byte(rom_addr, eff_mp);
               last_in      = pkt_ff == 7'd1;
               off_in       = off_ff + 1'b1;
               left_in      = left_ff - 1'b1;
               pkt_in       = pkt_ff - 1'b1;
               if (pkt_ff == 7'd1) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         base_ff      <= '0;
         off_ff       <= '0;
         left_ff      <= '0;
         zlp_ff       <= 1'b0;
         pkt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         off_ff       <= off_in;
         left_ff      <= left_in;
         zlp_ff       <= zlp_in;
         pkt_ff       <= pkt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_byte_ff <= data_byte_in;
         has_byte_ff  <= has_byte_in;
         last_ff      <= last_in;
         av_ff        <= av_in;
         addr_ff      <= addr_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.data_byte     = data_byte_ff;
   assign rsp_ch.has_byte      = has_byte_ff;
   assign rsp_ch.packet_last   = last_ff;
   assign rsp_ch.address_valid = av_ff;
   assign rsp_ch.new_address   = addr_ff;

endmodule

FILE: rtl/usb_ep0_descriptor_responder.sv
// top level: usb endpoint zero descriptor responder
//
//   channel | dir | transfer
//   req_ch  | in  | one decoded setup packet or in-done event
//   rsp_ch  | out | one packet byte, or one zero-length/address result
//   csr_ch  | in  | max packet size write, always ready
//
// a packet goes out from the queue head in steps: the command is taken, the packet
// is sized, then the rom gives one byte per cycle while the response register is free.
// an address result is emitted as its command is taken, a zero-length one at sizing.
// reset clears the transfer state and the queue and sets max packet to 16.
// a two-entry command queue lets requests be taken while the back end stalls.
`timescale 1ns / 1ps
module usb_ep0_descriptor_responder
   import uedr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   uedr_req_if.sink   req_ch,
   uedr_rsp_if.source rsp_ch,
   uedr_csr_if.sink   csr_ch
);

   logic [6:0]       max_packet_ff;
   logic [6:0]       max_packet_in;
   logic [6:0]       eff_mp;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          pop_cmd;
   queue_status_type q_status;

   assign csr_ch.ready  = 1'b1;
   assign max_packet_in = csr_ch.valid ? csr_ch.data : max_packet_ff;
   assign eff_mp        = eff_packet(max_packet_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_ff <= MaxPacketReset;
      end else begin
         max_packet_ff <= max_packet_in;
      end
   end

   uedr_front u_front (
      .req_ch   (req_ch),
      .q_status (q_status),
      .eff_mp   (eff_mp),
      .push     (push),
      .push_cmd (push_cmd)
   );

   uedr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   uedr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_cmd  (pop_cmd),
      .eff_mp   (eff_mp),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

   a_zlp_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.has_byte |-> rsp_ch.packet_last && rsp_ch.data_byte == 8'h00)
      else $error("zero-length result not marked last");

   a_addr_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.has_byte |-> !rsp_ch.address_valid && rsp_ch.new_address == 8'h00)
      else $error("address reported on a data byte");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("command popped from empty queue");

   a_full_push_pop: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("command pushed into full queue");

endmodule
